[sv/dfpe_pkg.sv]
// Shared types, constants and frame helpers for the DShot frame encoder.
`default_nettype none
package dfpe_pkg;

  localparam int FRAME_SLOTS = 18;
  localparam int FRAME_BITS  = 16;
  localparam int SLOT_W      = $clog2(FRAME_SLOTS);

  localparam int CODE_W  = 11;
  localparam int PCT_W   = 16;
  localparam int WIDTH_W = 16;
  localparam int PROD_W  = PCT_W + CODE_W;
  localparam int Y_W     = PROD_W - 8;
  localparam int QEST_W  = 13;

  // floor(y / 100) estimate: y * RECIP >> RECIP_SH is low by at most one
  localparam int RECIP_W  = 13;
  localparam int RECIP_SH = 19;
  localparam logic [RECIP_W-1:0] RECIP = 13'd5242;

  localparam logic [PCT_W-1:0] ONE_PERCENT_Q8 = 16'd256;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO    = 3'd4;

  localparam logic [CODE_W-1:0]  FLOOR_RST   = 11'd48;
  localparam logic [CODE_W-1:0]  CEILING_RST = 11'd2047;
  localparam logic [CODE_W-1:0]  IDLE_RST    = 11'd0;
  localparam logic [WIDTH_W-1:0] ONE_RST     = 16'd60;
  localparam logic [WIDTH_W-1:0] ZERO_RST    = 16'd30;

  typedef struct packed {
    logic [CODE_W-1:0]  throttle_floor;
    logic [CODE_W-1:0]  throttle_ceiling;
    logic [CODE_W-1:0]  idle_code;
    logic [WIDTH_W-1:0] one_high_time;
    logic [WIDTH_W-1:0] zero_high_time;
  } cfg_t;

  // append the XOR nibble checksum to the code and telemetry bit
  function automatic logic [FRAME_BITS-1:0] build_frame(input logic [CODE_W-1:0] code,
                                                        input logic tel);
    logic [11:0] twelve;
    logic [3:0]  sum;
    twelve = {code, tel};
    sum    = twelve[3:0] ^ twelve[7:4] ^ twelve[11:8];
    return {twelve, sum};
  endfunction

endpackage
`default_nettype wire

[sv/dshot_frame_pulse_encoder_top.sv]
// DShot frame encoder: one motor command in, eighteen timer compare slots out.
// A command passes the product and quotient stages before the emitter takes it.
// Output runs at one slot per cycle while out_stall is low; the next frame is
// computed while the current one is sent and follows its last slot directly.
// The slot emitter sets the rate: one compare value per cycle unless stalled.
// Reset (synchronous, rst high) empties the pipeline and restores the registers.
`default_nettype none
module dshot_frame_pulse_encoder_top import dfpe_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [PCT_W-1:0]     throttle_q8,
  input  wire logic                 motor_armed,
  input  wire logic                 want_telemetry,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [WIDTH_W-1:0]        pulse_width,
  output logic [FRAME_BITS-1:0]     frame_word,
  output logic                      is_last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDTH_W-1:0]   cfg_data
);

  cfg_t                  cfg;
  logic                  frame_valid;
  logic                  frame_take;
  logic [FRAME_BITS-1:0] frame;

  dfpe_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dfpe_code u_code (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .throttle_q8    (throttle_q8),
    .motor_armed    (motor_armed),
    .want_telemetry (want_telemetry),
    .frame_valid    (frame_valid),
    .frame_take     (frame_take),
    .frame          (frame)
  );

  dfpe_serial u_serial (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .frame_valid (frame_valid),
    .frame_take  (frame_take),
    .frame       (frame),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pulse_width (pulse_width),
    .frame_word  (frame_word),
    .is_last     (is_last)
  );

endmodule
`default_nettype wire

[sv/dfpe_regs.sv]
// Configuration register file for the DShot frame encoder.
`default_nettype none
module dfpe_regs import dfpe_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WIDTH_W-1:0]   cfg_data,
  output cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_floor   <= FLOOR_RST;
      cfg.throttle_ceiling <= CEILING_RST;
      cfg.idle_code        <= IDLE_RST;
      cfg.one_high_time    <= ONE_RST;
      cfg.zero_high_time   <= ZERO_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FLOOR:   cfg.throttle_floor   <= cfg_data[CODE_W-1:0];
        REG_CEILING: cfg.throttle_ceiling <= cfg_data[CODE_W-1:0];
        REG_IDLE:    cfg.idle_code        <= cfg_data[CODE_W-1:0];
        REG_ONE:     cfg.one_high_time    <= cfg_data;
        REG_ZERO:    cfg.zero_high_time   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/dfpe_code.sv]
// Throttle scaling and frame build pipeline: product, quotient estimate, frame.
`default_nettype none
module dfpe_code import dfpe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PCT_W-1:0]      throttle_q8,
  input  wire logic                  motor_armed,
  input  wire logic                  want_telemetry,
  output logic                       frame_valid,
  input  wire logic                  frame_take,
  output logic [FRAME_BITS-1:0]      frame
);

  logic [CODE_W-1:0] span;
  logic              s1_valid;
  logic [PROD_W-1:0] s1_prod;
  logic              s1_idle;
  logic              s1_tel;
  logic              s2_valid;
  logic [Y_W-1:0]    s2_y;
  logic [QEST_W-1:0] s2_qest;
  logic              s2_idle;
  logic              s2_tel;
  logic              s1_move;
  logic              s2_free;
  logic              in_take;

  logic [Y_W+RECIP_W-1:0] y_recip;
  logic [Y_W:0]           q100;
  logic [Y_W:0]           rem;
  logic [QEST_W-1:0]      quot;
  logic [QEST_W:0]        code_sum;
  logic [CODE_W-1:0]      code;

  assign span = (cfg.throttle_ceiling > cfg.throttle_floor) ?
                (cfg.throttle_ceiling - cfg.throttle_floor) : '0;

  assign s2_free  = !s2_valid || frame_take;
  assign s1_move  = s1_valid && s2_free;
  assign in_stall = s1_valid && !s2_free;
  assign in_take  = in_valid && !in_stall;

  assign y_recip = s1_prod[PROD_W-1:8] * RECIP;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (frame_take) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_prod <= throttle_q8 * span;
      s1_idle <= !motor_armed || (throttle_q8 < ONE_PERCENT_Q8);
      s1_tel  <= want_telemetry;
    end
    if (s1_move) begin
      s2_y    <= s1_prod[PROD_W-1:8];
      s2_qest <= y_recip[RECIP_SH +: QEST_W];
      s2_idle <= s1_idle;
      s2_tel  <= s1_tel;
    end
  end

  // correct the low estimate, add the floor and saturate at the ceiling; idle uses idle_code
  always_comb begin
    q100     = {{(Y_W+1-QEST_W){1'b0}}, s2_qest} * (Y_W+1)'(100);
    rem      = {1'b0, s2_y} - q100;
    quot     = s2_qest + QEST_W'(rem >= (Y_W+1)'(100));
    code_sum = {3'b000, cfg.throttle_floor} + {1'b0, quot};
    if (s2_idle) begin
      code = cfg.idle_code;
    end else if (code_sum > {3'b000, cfg.throttle_ceiling}) begin
      code = cfg.throttle_ceiling;
    end else begin
      code = code_sum[CODE_W-1:0];
    end
  end

  assign frame_valid = s2_valid;
  assign frame       = build_frame(code, s2_tel);

endmodule
`default_nettype wire

[sv/dfpe_serial.sv]
// Slot emitter: sends one frame as a train of compare widths and gap slots.
`default_nettype none
module dfpe_serial import dfpe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cfg_t                  cfg,
  input  wire logic                  frame_valid,
  output logic                       frame_take,
  input  wire logic [FRAME_BITS-1:0] frame,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [WIDTH_W-1:0]         pulse_width,
  output logic [FRAME_BITS-1:0]      frame_word,
  output logic                       is_last
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);
  localparam logic [SLOT_W-1:0] TOP_BIT   = SLOT_W'(FRAME_BITS - 1);

  logic                     busy;
  logic [SLOT_W-1:0]        slot;
  logic [FRAME_BITS-1:0]    held;
  logic                     out_take;
  logic [$clog2(FRAME_BITS)-1:0] bit_idx;

  assign out_take   = busy && !out_stall;
  assign is_last    = (slot == LAST_SLOT);
  assign frame_take = frame_valid && (!busy || (out_take && is_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= '0;
    end else if (frame_take) begin
      busy <= 1'b1;
      slot <= '0;
    end else if (out_take) begin
      // drop busy after the final slot, else advance
      if (is_last) begin
        busy <= 1'b0;
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      held <= frame;
    end
  end

  assign bit_idx = $clog2(FRAME_BITS)'(TOP_BIT - slot);

  always_comb begin
    if (slot > TOP_BIT) begin
      pulse_width = '0;
    end else if (held[bit_idx]) begin
      pulse_width = cfg.one_high_time;
    end else begin
      pulse_width = cfg.zero_high_time;
    end
  end

  assign out_valid  = busy;
  assign frame_word = held;

endmodule
`default_nettype wire

[sv/dfpe_checker.sv]
// Port-level checks for the DShot frame encoder, bound to the top level.
`default_nettype none
module dfpe_checker import dfpe_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [WIDTH_W-1:0]    pulse_width,
  input wire logic [FRAME_BITS-1:0] frame_word,
  input wire logic                  is_last
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a frame keeps sending until its last slot, with the same frame word
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_last |=> out_valid && $stable(frame_word))
    else $error("frame run broken before its last slot");

  // the last slot is a gap
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_last |-> pulse_width == '0)
    else $error("last slot is not a gap");

  // a stalled slot holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pulse_width) && $stable(is_last))
    else $error("stalled slot changed");

endmodule

bind dshot_frame_pulse_encoder_top dfpe_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pulse_width (pulse_width),
  .frame_word  (frame_word),
  .is_last     (is_last)
);
`default_nettype wire

[bench/dfpe_slot_board_pkg.sv]
// Frame prediction and slot checking for the DShot frame encoder bench.
package dfpe_slot_board_pkg;
  import dfpe_pkg::*;

  localparam int unsigned FULL_SCALE_Q8 = 25600;
  localparam int unsigned PCT_ONE_Q8    = 256;

  typedef struct packed {
    logic [WIDTH_W-1:0]    width;
    logic [FRAME_BITS-1:0] frame;
    logic                  last;
  } slot_t;

  class dshot_slot_board;
    cfg_t  regs;
    slot_t slots_due[$];
    int    errors;

    function new();
      errors = 0;
      regs.throttle_floor   = FLOOR_RST;
      regs.throttle_ceiling = CEILING_RST;
      regs.idle_code        = IDLE_RST;
      regs.one_high_time    = ONE_RST;
      regs.zero_high_time   = ZERO_RST;
    endfunction

    function void report_mismatch(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endfunction

    // indexes past the register list are dropped
    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] data);
      case (idx)
        REG_FLOOR:   regs.throttle_floor   = data[CODE_W-1:0];
        REG_CEILING: regs.throttle_ceiling = data[CODE_W-1:0];
        REG_IDLE:    regs.idle_code        = data[CODE_W-1:0];
        REG_ONE:     regs.one_high_time    = data;
        REG_ZERO:    regs.zero_high_time   = data;
        default: ;
      endcase
    endfunction

    function logic [CODE_W-1:0] throttle_code(logic [PCT_W-1:0] pct, logic armed);
      int unsigned lo;
      int unsigned hi;
      int unsigned span;
      int unsigned code;
      lo = regs.throttle_floor;
      hi = regs.throttle_ceiling;
      if (!armed || pct < PCT_ONE_Q8) return regs.idle_code;
      span = (hi > lo) ? hi - lo : 0;
      // keep the sum at full width, then clamp
      code = lo + (int'(pct) * span) / FULL_SCALE_Q8;
      if (code > hi) code = hi;
      return code[CODE_W-1:0];
    endfunction

    function void note_command(logic [PCT_W-1:0] pct, logic armed, logic tel);
      logic [11:0]           payload;
      logic [3:0]            crc;
      logic [FRAME_BITS-1:0] frame;
      slot_t                 s;
      payload = {throttle_code(pct, armed), tel};
      crc     = payload[11:8] ^ payload[7:4] ^ payload[3:0];
      frame   = {payload, crc};
      for (int i = 0; i < FRAME_SLOTS; i++) begin
        s.frame = frame;
        s.last  = (i == FRAME_SLOTS - 1);
        if (i < FRAME_BITS)
          s.width = frame[FRAME_BITS-1-i] ? regs.one_high_time : regs.zero_high_time;
        else
          s.width = '0;
        slots_due.push_back(s);
      end
    endfunction

    function void check_slot(logic [WIDTH_W-1:0] pw, logic [FRAME_BITS-1:0] fw, logic last);
      slot_t due;
      if (slots_due.size() == 0) begin
        report_mismatch($sformatf("unexpected slot pulse_width %0d frame_word %h", pw, fw));
        return;
      end
      due = slots_due.pop_front();
      if (pw !== due.width)
        report_mismatch($sformatf("pulse_width got %0d want %0d", pw, due.width));
      if (fw !== due.frame)
        report_mismatch($sformatf("frame_word got %h want %h", fw, due.frame));
      if (last !== due.last)
        report_mismatch($sformatf("is_last got %b want %b (frame %h)", last, due.last,
                                  due.frame));
    endfunction

    function int pending();
      return slots_due.size();
    endfunction
  endclass

endpackage

[bench/tb_dshot_frame_pulse_encoder_top.sv]
// Self-checking bench for the DShot frame encoder: directed and random commands.
module tb_dshot_frame_pulse_encoder_top;
  import dfpe_pkg::*;
  import dfpe_slot_board_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_C = 3'd7;
  localparam int RANDOM_PHASES    = 6;
  localparam int ITEMS_PER_PHASE  = 25;
  localparam int HOLD_OFF_CYCLES  = 300;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [PCT_W-1:0]     throttle_q8;
  logic                 motor_armed;
  logic                 want_telemetry;
  logic                 out_valid;
  logic                 out_stall;
  logic [WIDTH_W-1:0]   pulse_width;
  logic [FRAME_BITS-1:0] frame_word;
  logic                 is_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WIDTH_W-1:0]   cfg_data;

  logic calm;
  logic sink_hold;
  int   commands_sent = 0;

  dshot_slot_board board = new();

  dshot_frame_pulse_encoder_top DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .throttle_q8    (throttle_q8),
    .motor_armed    (motor_armed),
    .want_telemetry (want_telemetry),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .pulse_width    (pulse_width),
    .frame_word     (frame_word),
    .is_last        (is_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // valid stays high across back-to-back writes; drop lowers it after this one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WIDTH_W-1:0] data,
                           input bit drop);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.apply_reg(idx, data);
    if (drop) cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [WIDTH_W-1:0] lo, input logic [WIDTH_W-1:0] hi,
                               input logic [WIDTH_W-1:0] idle, input logic [WIDTH_W-1:0] one,
                               input logic [WIDTH_W-1:0] zero);
    write_reg(REG_FLOOR, lo, 1'b0);
    write_reg(REG_CEILING, hi, 1'b0);
    write_reg(REG_IDLE, idle, 1'b0);
    write_reg(REG_ONE, one, 1'b0);
    write_reg(REG_ZERO, zero, 1'b1);
  endtask

  task automatic send_command(input logic [PCT_W-1:0] pct, input logic armed, input logic tel);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    throttle_q8    <= pct;
    motor_armed    <= armed;
    want_telemetry <= tel;
    do @(posedge clk); while (in_stall);
    board.note_command(pct, armed, tel);
    commands_sent++;
  endtask

  // drain every slot, then leave room for the pipeline before touching registers
  task automatic end_phase();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [WIDTH_W-1:0] pick_code();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'h07FF;
      default: return WIDTH_W'($urandom);
    endcase
  endfunction

  function automatic logic [WIDTH_W-1:0] pick_width();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return 16'hFFFF;
      default: return WIDTH_W'($urandom);
    endcase
  endfunction

  function automatic logic [PCT_W-1:0] pick_throttle();
    case ($urandom_range(0, 7))
      0:       return PCT_W'($urandom_range(0, 255));
      1:       return PCT_W'($urandom_range(250, 262));
      2:       return PCT_W'($urandom_range(25500, 25700));
      3:       return 16'hFFFF - PCT_W'($urandom_range(0, 15));
      default: return PCT_W'($urandom);
    endcase
  endfunction

  task automatic random_settings();
    case ($urandom_range(0, 3))
      0: write_reg(REG_UNUSED_A, WIDTH_W'($urandom), 1'b0);
      1: write_reg(REG_UNUSED_B, WIDTH_W'($urandom), 1'b0);
      2: write_reg(REG_UNUSED_C, WIDTH_W'($urandom), 1'b0);
      default: ;
    endcase
    load_settings(pick_code(), pick_code(), pick_code(), pick_width(), pick_width());
  endtask

  // receiver: random stall bursts, plus the long hold-off when requested
  initial begin : slot_sink
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        board.check_slot(pulse_width, frame_word, is_last);
      if (burst > 0)
        burst--;
      else if (!calm && $urandom_range(0, 7) == 0)
        burst = $urandom_range(1, 10);
      out_stall <= sink_hold || (burst > 0);
    end
  end

  // hold the output off long enough for the block to fill and stall its input
  initial begin : hold_off
    sink_hold <= 1'b0;
    wait (commands_sent >= 70);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin : stimulus
    rst            <= 1'b1;
    calm           <= 1'b0;
    in_valid       <= 1'b0;
    throttle_q8    <= '0;
    motor_armed    <= 1'b0;
    want_telemetry <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // registers at reset values: thresholds, full scale, overrange, disarmed
    send_command(16'd0, 1'b1, 1'b0);
    send_command(16'd255, 1'b1, 1'b1);
    send_command(16'd256, 1'b1, 1'b0);
    send_command(16'd25600, 1'b1, 1'b1);
    send_command(16'hFFFF, 1'b1, 1'b0);
    send_command(16'hFFFF, 1'b0, 1'b1);
    send_command(16'h5555, 1'b1, 1'b1);
    send_command(16'hAAAA, 1'b1, 1'b0);
    end_phase();

    // widest span and extreme widths; writes past the list must be ignored
    write_reg(REG_UNUSED_A, 16'hFFFF, 1'b0);
    write_reg(REG_UNUSED_B, 16'hFFFF, 1'b0);
    write_reg(REG_UNUSED_C, 16'hFFFF, 1'b0);
    load_settings(16'h0000, 16'hFFFF, 16'h07FF, 16'hFFFF, 16'h0000);
    send_command(16'd0, 1'b0, 1'b1);
    send_command(16'd256, 1'b1, 1'b1);
    send_command(16'd12800, 1'b1, 1'b0);
    send_command(16'hFFFF, 1'b1, 1'b1);
    end_phase();

    // floor above ceiling: code clamps to the ceiling
    load_settings(16'd1500, 16'd200, 16'hF955, 16'h0000, 16'hFFFF);
    send_command(16'd256, 1'b1, 1'b0);
    send_command(16'd40000, 1'b1, 1'b1);
    send_command(16'd100, 1'b1, 1'b1);
    end_phase();

    // floor equal to ceiling, upper data bits set on the code registers
    load_settings(16'hFBE8, 16'h03E8, 16'h02AA, 16'h8001, 16'h7FFE);
    send_command(16'd256, 1'b1, 1'b0);
    send_command(16'hFFFF, 1'b1, 1'b1);
    send_command(16'd30000, 1'b0, 1'b0);
    end_phase();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_settings();
      if (p == RANDOM_PHASES - 1) calm <= 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_command(pick_throttle(), $urandom_range(0, 4) != 0, 1'($urandom_range(0, 1)));
      end_phase();
    end

    repeat (20) @(posedge clk);
    if (board.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
